[rtl/lkvc_pkg.sv]
// shared types and constants for the lru key-value cache
// no dependencies; used by lkvc_scan and lru_key_value_cache
`default_nettype none

package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;

    // status of one search pass over the entries
    typedef struct packed {
        logic hit;
        logic free;
        logic victim;
    } scan_flags_t;

endpackage

`default_nettype wire

[rtl/lru_key_value_cache.sv]
// fully associative key-value cache with least-recently-used replacement
// depends on lkvc_pkg and lkvc_scan
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tdata {store_value, lookup_key}, s_tuser operation
//  m_      | out | m_tvalid / m_tready  | m_tdata read_value, m_tuser found
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_data capacity_in_use
//
// an item takes one search sweep and one rank sweep over the entry memories, one entry
// a cycle through the single read port, plus accept and decide.
// a get that misses skips the rank sweep.
// reset empties the cache at once (valid bits and use count); capacity resets to 16.
// a result waits in the output register; a get whose result finds it still full holds
// in the decide step until the beat is taken. cfg_ready is always high.
`default_nettype none

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [31:0] lookup_key, [63:32] store_value
    input  wire  [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] read_value
    output logic [0:0]  m_tuser,   // [0] found
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [4:0]  cfg_data
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam int THR_W  = RANK_W + 1;

    localparam logic [CNT_W-1:0] IDX_END  = CNT_W'(MAX_ENTRIES);
    localparam logic [CMP_W-1:0] CAP_MAX  = CMP_W'(MAX_ENTRIES);
    localparam logic [CMP_W-1:0] CAP_MIN  = CMP_W'(1);
    localparam logic [THR_W-1:0] THR_ALL  = {1'b1, {RANK_W{1'b0}}};
    localparam logic [4:0]       CAP_RST  = 5'd16;
    localparam logic [31:0]      MISS_VAL = 32'hFFFF_FFFF;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;

    logic [2:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic                       op_reg;
    logic [31:0]                key_reg, val_reg;
    logic [4:0]                 cap_reg;
    logic [CNT_W-1:0]           used_reg, used_next;
    logic [MAX_ENTRIES-1:0]     valid_reg, valid_next;
    logic [IDX_W-1:0]           target_reg, target_next;
    logic [THR_W-1:0]           thr_reg, thr_next;

    logic                       rd_act_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic [IDX_W-1:0]           rd_addr;
    logic [31:0]                key_rd_reg, val_rd_reg;
    logic [RANK_W-1:0]          rank_rd_reg;

    logic [31:0]                key_mem  [MAX_ENTRIES];
    logic [31:0]                val_mem  [MAX_ENTRIES];
    logic [RANK_W-1:0]          rank_mem [MAX_ENTRIES];

    logic                       key_we, val_we, rank_we;
    logic [IDX_W-1:0]           kv_wa;
    logic [31:0]                val_wd;
    logic [RANK_W-1:0]          rank_wd;

    logic                       m_tvalid_reg;
    logic [31:0]                m_tdata_reg;
    logic                       m_tuser_reg;
    logic                       out_load;
    logic                       out_found;
    logic [31:0]                out_value;

    logic                       accept, sweeping, scan_clear;
    logic [CMP_W-1:0]           cap_ext, cap_eff;
    logic                       insert_ok;

    lkvc_pkg::scan_flags_t      sc_flags;
    logic [IDX_W-1:0]           sc_hit_idx, sc_free_idx, sc_victim_idx;
    logic [RANK_W-1:0]          sc_hit_rank, sc_victim_rank;
    logic [31:0]                sc_hit_value;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign sweeping  = (state_reg == S_SCAN) || (state_reg == S_UPD);
    assign rd_addr   = idx_reg[IDX_W-1:0];
    assign scan_clear = accept;

    lkvc_scan #(
        .IDX_W  (IDX_W),
        .RANK_W (RANK_W)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (scan_clear),
        .step        (rd_act_reg && (state_reg == S_SCAN)),
        .entry_idx   (rd_idx_reg),
        .entry_valid (valid_reg[rd_idx_reg]),
        .entry_key   (key_rd_reg),
        .entry_rank  (rank_rd_reg),
        .entry_value (val_rd_reg),
        .search_key  (key_reg),
        .flags       (sc_flags),
        .hit_idx     (sc_hit_idx),
        .hit_rank    (sc_hit_rank),
        .hit_value   (sc_hit_value),
        .free_idx    (sc_free_idx),
        .victim_idx  (sc_victim_idx),
        .victim_rank (sc_victim_rank)
    );

    // capacity 0 acts as 1, anything above the store size acts as the store size
    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext < CAP_MIN) begin
            cap_eff = CAP_MIN;
        end else if (cap_ext > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end else begin
            cap_eff = cap_ext;
        end
        insert_ok = (CMP_W'(used_reg) < cap_eff) && sc_flags.free;
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        used_next   = used_reg;
        valid_next  = valid_reg;
        target_next = target_reg;
        thr_next    = thr_reg;
        key_we      = 1'b0;
        val_we      = 1'b0;
        kv_wa       = sc_hit_idx;
        val_wd      = val_reg;
        rank_we     = 1'b0;
        rank_wd     = '0;
        out_load    = 1'b0;
        out_found   = 1'b0;
        out_value   = MISS_VAL;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (idx_reg == IDX_END) begin
                    state_next = S_DECIDE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DECIDE: begin
                idx_next = '0;
                if (op_reg == OP_GET) begin
                    if (!m_tvalid_reg || m_tready) begin
                        out_load = 1'b1;
                        if (sc_flags.hit) begin
                            out_found   = 1'b1;
                            out_value   = sc_hit_value;
                            target_next = sc_hit_idx;
                            thr_next    = {1'b0, sc_hit_rank};
                            state_next  = S_UPD;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                end else begin
                    val_we     = 1'b1;
                    state_next = S_UPD;
                    if (sc_flags.hit) begin
                        kv_wa       = sc_hit_idx;
                        target_next = sc_hit_idx;
                        thr_next    = {1'b0, sc_hit_rank};
                    end else if (insert_ok) begin
                        // new entry: every live entry ages by one
                        key_we      = 1'b1;
                        kv_wa       = sc_free_idx;
                        target_next = sc_free_idx;
                        thr_next    = THR_ALL;
                        valid_next[sc_free_idx] = 1'b1;
                        used_next   = used_reg + 1'b1;
                    end else begin
                        key_we      = 1'b1;
                        kv_wa       = sc_victim_idx;
                        target_next = sc_victim_idx;
                        thr_next    = {1'b0, sc_victim_rank};
                    end
                end
            end
            S_UPD: begin
                // read of entry i overlaps the rank write of entry i-1
                if (rd_act_reg) begin
                    if (rd_idx_reg == target_reg) begin
                        rank_we = 1'b1;
                        rank_wd = '0;
                    end else if (valid_reg[rd_idx_reg] &&
                                 ({1'b0, rank_rd_reg} < thr_reg)) begin
                        rank_we = 1'b1;
                        rank_wd = rank_rd_reg + 1'b1;
                    end
                end
                if (idx_reg == IDX_END) begin
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            used_reg   <= '0;
            valid_reg  <= '0;
            cap_reg    <= CAP_RST;
            rd_act_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            used_reg   <= used_next;
            valid_reg  <= valid_next;
            rd_act_reg <= sweeping && (idx_reg != IDX_END);
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_tuser[0];
            key_reg <= s_tdata[31:0];
            val_reg <= s_tdata[63:32];
        end
        target_reg <= target_next;
        thr_reg    <= thr_next;
        rd_idx_reg <= rd_addr;
    end

    // entry memories: one read port for the sweeps, one write port each
    always_ff @(posedge aclk) begin
        key_rd_reg <= key_mem[rd_addr];
        if (key_we) begin
            key_mem[kv_wa] <= key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        val_rd_reg <= val_mem[rd_addr];
        if (val_we) begin
            val_mem[kv_wa] <= val_wd;
        end
    end

    always_ff @(posedge aclk) begin
        rank_rd_reg <= rank_mem[rd_addr];
        if (rank_we) begin
            rank_mem[rd_idx_reg] <= rank_wd;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= out_value;
            m_tuser_reg <= out_found;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_used_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'($countones(valid_reg)) == used_reg)
        else $error("use count differs from valid entries");

    a_used_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= IDX_END)
        else $error("use count above store size");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("ready right after an accepted beat");

    a_rank_write_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        rank_we |-> (state_reg == S_UPD))
        else $error("rank written outside the rank sweep");

    a_result_only_for_get: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (op_reg == OP_GET) && (state_reg == S_DECIDE))
        else $error("result produced for a set");

endmodule

`default_nettype wire

[rtl/lkvc_scan.sv]
// entry compare unit: takes one stored entry per step and keeps hit, free and victim
// depends on lkvc_pkg
`default_nettype none

module lkvc_scan #(
    parameter int IDX_W  = 4,
    parameter int RANK_W = 4
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          clear,
    input  wire                          step,
    input  wire  [IDX_W-1:0]             entry_idx,
    input  wire                          entry_valid,
    input  wire  [lkvc_pkg::KEY_W-1:0]   entry_key,
    input  wire  [RANK_W-1:0]            entry_rank,
    input  wire  [lkvc_pkg::VAL_W-1:0]   entry_value,
    input  wire  [lkvc_pkg::KEY_W-1:0]   search_key,
    output lkvc_pkg::scan_flags_t        flags,
    output logic [IDX_W-1:0]             hit_idx,
    output logic [RANK_W-1:0]            hit_rank,
    output logic [lkvc_pkg::VAL_W-1:0]   hit_value,
    output logic [IDX_W-1:0]             free_idx,
    output logic [IDX_W-1:0]             victim_idx,
    output logic [RANK_W-1:0]            victim_rank
);

    lkvc_pkg::scan_flags_t    flags_reg, flags_next;
    logic [IDX_W-1:0]         hit_idx_reg, free_idx_reg, victim_idx_reg;
    logic [RANK_W-1:0]        hit_rank_reg, victim_rank_reg;
    logic [lkvc_pkg::VAL_W-1:0] hit_value_reg;
    logic                     take_hit, take_free, take_victim;

    always_comb begin
        take_hit    = step && entry_valid && (entry_key == search_key) && !flags_reg.hit;
        take_free   = step && !entry_valid && !flags_reg.free;
        // strictly older wins, so the lowest index keeps a tie
        take_victim = step && entry_valid &&
                      (!flags_reg.victim || (entry_rank > victim_rank_reg));
        flags_next = flags_reg;
        if (take_hit) begin
            flags_next.hit = 1'b1;
        end
        if (take_free) begin
            flags_next.free = 1'b1;
        end
        if (take_victim) begin
            flags_next.victim = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_hit) begin
            hit_idx_reg   <= entry_idx;
            hit_rank_reg  <= entry_rank;
            hit_value_reg <= entry_value;
        end
        if (take_free) begin
            free_idx_reg <= entry_idx;
        end
        if (take_victim) begin
            victim_idx_reg  <= entry_idx;
            victim_rank_reg <= entry_rank;
        end
    end

    assign flags       = flags_reg;
    assign hit_idx     = hit_idx_reg;
    assign hit_rank    = hit_rank_reg;
    assign hit_value   = hit_value_reg;
    assign free_idx    = free_idx_reg;
    assign victim_idx  = victim_idx_reg;
    assign victim_rank = victim_rank_reg;

endmodule

`default_nettype wire

[bench/lkvc_checker.sv]
// bench-side op codes and the scoreboard for the lru key-value cache
// watches the config, request and result channels, predicts each get, compares
// depends on lkvc_pkg for key and value widths

package lkvc_tb_pkg;

    localparam int CACHE_DEPTH = 16;

    typedef enum bit {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } cache_op_t;

endpackage

module lkvc_checker (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire  [63:0]  s_tdata,    // [31:0] lookup_key, [63:32] store_value
    input  wire  [0:0]   s_tuser,    // [0] operation
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [31:0]  m_tdata,    // [31:0] read_value
    input  wire  [0:0]   m_tuser,    // [0] found
    input  wire          cfg_valid,
    input  wire          cfg_ready,
    input  wire  [4:0]   cfg_data,
    output int unsigned  mismatches,
    output int unsigned  outstanding,
    output int unsigned  reads_checked,
    output int unsigned  hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;
    import lkvc_tb_pkg::*;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value;
    } read_result_t;

    read_result_t     expected_reads [$];

    // shadow copy of the cache contents
    logic [KEY_W-1:0] line_key   [CACHE_DEPTH];
    logic [VAL_W-1:0] line_value [CACHE_DEPTH];
    bit               line_live  [CACHE_DEPTH];
    int               line_age   [CACHE_DEPTH];   // 0 = most recently used
    int               lines_used;
    logic [4:0]       capacity;

    function automatic int capacity_limit();
        if (capacity == 5'd0) return 1;
        if (capacity > CACHE_DEPTH) return CACHE_DEPTH;
        return int'(capacity);
    endfunction

    function automatic int find_line(input logic [KEY_W-1:0] key);
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (line_live[i] && line_key[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic void make_newest(input int slot);
        int old_age;
        old_age = line_age[slot];
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (line_live[i] && line_age[i] < old_age) line_age[i]++;
        end
        line_age[slot] = 0;
    endfunction

    // applies one request to the shadow cache; returns 1 when a get answers
    function automatic bit cache_access(input cache_op_t op, input logic [KEY_W-1:0] key,
                                        input logic [VAL_W-1:0] value,
                                        output read_result_t answer);
        int slot;
        int victim;
        int oldest;
        slot = find_line(key);
        answer = '0;
        if (op == OP_GET) begin
            if (slot >= 0) begin
                answer.found = 1'b1;
                answer.value = line_value[slot];
                make_newest(slot);
            end else begin
                answer.found = 1'b0;
                answer.value = '1;
            end
            return 1'b1;
        end
        if (slot >= 0) begin
            line_value[slot] = value;
            make_newest(slot);
            return 1'b0;
        end
        if (lines_used < capacity_limit()) begin
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                if (!line_live[i]) begin
                    for (int j = 0; j < CACHE_DEPTH; j++) begin
                        if (line_live[j]) line_age[j]++;
                    end
                    line_live[i]  = 1'b1;
                    line_key[i]   = key;
                    line_value[i] = value;
                    line_age[i]   = 0;
                    lines_used++;
                    return 1'b0;
                end
            end
        end
        // full, or capacity shrunk below use: replace the least recent line
        victim = -1;
        oldest = 0;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (line_live[i] && (victim < 0 || line_age[i] > oldest)) begin
                victim = i;
                oldest = line_age[i];
            end
        end
        if (victim >= 0) begin
            line_key[victim]   = key;
            line_value[victim] = value;
            make_newest(victim);
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at %0t: %s, got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        read_result_t got_beat;
        read_result_t want_beat;
        bit           answers;
        if (!aresetn) begin
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                line_live[i] = 1'b0;
                line_age[i]  = 0;
            end
            lines_used = 0;
            capacity   = 5'd16;
            expected_reads.delete();
            outstanding = 0;
        end else begin
            if (cfg_valid && cfg_ready) capacity = cfg_data;
            // retire the result beat before queuing a new get
            if (m_tvalid && m_tready) begin
                got_beat.found = m_tuser[0];
                got_beat.value = m_tdata;
                if (expected_reads.size() == 0) begin
                    flag_mismatch("result beat with no get pending", m_tdata, '1);
                end else begin
                    want_beat = expected_reads.pop_front();
                    outstanding--;
                    reads_checked++;
                    if (want_beat.found) hits_seen++;
                    if (got_beat.found !== want_beat.found)
                        flag_mismatch("found", 32'(got_beat.found), 32'(want_beat.found));
                    if (got_beat.value !== want_beat.value)
                        flag_mismatch("read_value", got_beat.value, want_beat.value);
                end
            end
            if (s_tvalid && s_tready) begin
                answers = cache_access(cache_op_t'(s_tuser[0]), s_tdata[31:0],
                                       s_tdata[63:32], want_beat);
                if (answers) begin
                    expected_reads.push_back(want_beat);
                    outstanding++;
                end
            end
        end
    end

endmodule

[bench/tb_lru_key_value_cache.sv]
// top of the lru key-value cache bench: clock, reset, request and config stimulus, verdict
// depends on lkvc_pkg, lkvc_checker.sv (lkvc_tb_pkg, lkvc_checker) and the rtl top

module tb_lru_key_value_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;
    import lkvc_tb_pkg::*;

    localparam int          SETTLE_CYCLES = 2 * CACHE_DEPTH + 16;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          PHASE_ITEMS   = 185;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // [31:0] lookup_key, [63:32] store_value
    logic [0:0]  s_tuser   = '0;   // [0] operation
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [31:0] read_value
    logic [0:0]  m_tuser;          // [0] found
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned reads_checked;
    int unsigned hits_seen;
    int unsigned items_sent;
    int unsigned writes_done;
    int unsigned cycle_count;
    bit          send_idle_on = 1'b1;
    bit          recv_idle_on = 1'b1;
    int          stall_left;

    always #10 aclk = ~aclk;

    lru_key_value_cache i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lkvc_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .reads_checked (reads_checked),
        .hits_seen     (hits_seen)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 45);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d gets still pending", cycle_count,
                     outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (recv_idle_on && $urandom_range(0, 99) < 25) begin
            stall_left <= idle_length() - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_op(input cache_op_t op, input logic [31:0] key,
                           input logic [31:0] value);
        int gap;
        if (send_idle_on && $urandom_range(0, 99) < 30) begin
            gap = idle_length();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= op;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
    endtask

    // hold requests until every get has answered and the last set has settled
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        drain_requests();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        writes_done++;
    endtask

    task automatic run_phase(input logic [4:0] cap, input int n_items);
        logic [31:0] key_pool [40];
        int          pool_n;
        int          span;
        logic [31:0] key;
        cache_op_t   op;
        write_capacity(cap);
        span   = (cap == 5'd0) ? 1 : ((cap > CACHE_DEPTH) ? CACHE_DEPTH : int'(cap));
        pool_n = $urandom_range(span + 3, 2 * span + 4);
        for (int i = 0; i < pool_n; i++) key_pool[i] = pick_word();
        for (int n = 0; n < n_items; n++) begin
            op  = $urandom_range(0, 1) ? OP_SET : OP_GET;
            // a small key pool keeps hits, updates and evictions frequent
            key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, pool_n - 1)]
                                               : $urandom;
            send_op(op, key, pick_word());
        end
    endtask

    initial begin
        logic [4:0] phase_cap [7];
        phase_cap = '{5'd1, 5'd16, 5'd3, 5'd31, 5'd0, 5'd9, 5'd20};
        phase_cap[5] = 5'($urandom_range(2, 15));
        phase_cap[6] = 5'($urandom_range(17, 30));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty cache, extreme keys and values, update of a present key
        send_op(OP_GET, 32'h8000_0000, 32'h0);
        send_op(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_op(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_op(OP_SET, 32'h0000_0000, 32'h0000_0000);
        send_op(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_GET, 32'h8000_0000, 32'h0);
        send_op(OP_GET, 32'h7FFF_FFFF, 32'h0);
        send_op(OP_GET, 32'h0000_0000, 32'h0);
        send_op(OP_GET, 32'hFFFF_FFFF, 32'h0);   // hit whose value looks like a miss
        send_op(OP_GET, 32'h0000_0001, 32'h0);
        send_op(OP_SET, 32'h0000_0000, 32'h1234_5678);
        send_op(OP_GET, 32'h0000_0000, 32'h0);

        // shrink below use: no line dropped, new keys replace the least recent
        write_capacity(5'd2);
        send_op(OP_SET, 32'h0000_0055, 32'h0000_00AA);
        send_op(OP_GET, 32'h8000_0000, 32'h0);
        send_op(OP_GET, 32'h0000_0055, 32'h0);
        send_op(OP_SET, 32'h0000_0066, 32'h5555_AAAA);
        send_op(OP_GET, 32'h7FFF_FFFF, 32'h0);

        // zero acts as one
        write_capacity(5'd0);
        send_op(OP_SET, 32'h0000_0077, 32'h0000_0001);
        send_op(OP_GET, 32'h0000_0077, 32'h0);
        send_op(OP_GET, 32'h0000_0066, 32'h0);

        // above the depth acts as full depth, free lines fill again
        write_capacity(5'd31);
        send_op(OP_SET, 32'h0000_0088, 32'h0000_0002);
        send_op(OP_GET, 32'h0000_0088, 32'h0);
        send_op(OP_GET, 32'h0000_0055, 32'h0);

        for (int p = 0; p < 7; p++) begin
            send_idle_on = (p != 2) && ($urandom_range(0, 4) != 0);
            recv_idle_on = (p != 2) && ($urandom_range(0, 4) != 0);
            run_phase(phase_cap[p], PHASE_ITEMS);
        end

        drain_requests();
        $display("%0d requests, %0d gets checked (%0d hits), %0d capacity writes",
                 items_sent, reads_checked, hits_seen, writes_done);
        $display("capacities 0, 1, 2, 3, 16, 31 and random, shrinking below use included");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/lkvc_pkg.sv
rtl/lkvc_scan.sv
rtl/lru_key_value_cache.sv
bench/lkvc_checker.sv
bench/tb_lru_key_value_cache.sv
